// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/icsp_pkg.sv -----
// ----------------------------------------------------------------------------
// icsp_pkg
// types and constants of the two-wire programming command serializer
// ----------------------------------------------------------------------------
package icsp_pkg;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_SIX    = 3'd1;
    localparam logic [2:0] KIND_REGOUT = 3'd2;
    localparam logic [2:0] KIND_KEY    = 3'd3;
    localparam logic [2:0] KIND_BIT    = 3'd4;
    localparam logic [2:0] KIND_IDLE   = 3'd0;

    localparam int COUNT_W = 6;
    localparam int WORD_W  = 16;

    localparam logic [COUNT_W-1:0] SIX_CLOCKS    = 6'd28;
    localparam logic [COUNT_W-1:0] REGOUT_CLOCKS = 6'd12;
    localparam logic [COUNT_W-1:0] KEY_CLOCKS    = 6'd32;
    localparam logic [COUNT_W-1:0] BIT_CLOCKS    = 6'd1;
    localparam logic [COUNT_W-1:0] READ_CLOCKS   = 6'd16;

    localparam logic [31:0] REGOUT_CTRL = 32'h0000_0001;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] payload;
        logic        data_pin_in;
    } cmd_t;

    typedef struct packed {
        logic              clock_active;
        logic              data_pin_out;
        logic              data_pin_drive;
        logic [WORD_W-1:0] read_word;
        logic              word_valid;
        logic              last_bit;
        logic              command_dropped;
    } res_t;

endpackage

// ----- rtl/core/icsp_stream_if.sv -----
// ----------------------------------------------------------------------------
// icsp_stream_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface icsp_cmd_if;
    logic            valid;
    logic            ready;
    icsp_pkg::cmd_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface icsp_res_if;
    logic            valid;
    logic            ready;
    icsp_pkg::res_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/icsp_command_serializer_unit.sv -----
// ----------------------------------------------------------------------------
// icsp_command_serializer_unit
// two-wire programming master: takes commands and clock ticks, emits one
// result beat per tick or dropped command
// ----------------------------------------------------------------------------
// a result beat is registered: it enters the output register when that is
// empty or being taken, else the skid entry; throughput: one beat per cycle
// while the skid entry is empty, bounded by the single state update
// a two-entry output (register plus skid) keeps cmd.ready high while one
// result waits; reset clears all control state and both output entries
`include "assert_macros.svh"

module icsp_command_serializer_unit
(
    input  logic                clk,
    input  logic                rst_n,
    icsp_cmd_if.sink            cmd,
    icsp_res_if.source          res
);
    import icsp_pkg::*;

    logic [31:0]        shift_reg,     shift_next;
    logic [COUNT_W-1:0] bits_left_reg, bits_left_next;
    logic [2:0]         cmd_kind_reg,  cmd_kind_next;
    logic               read_phase_reg, read_phase_next;
    logic [WORD_W-1:0]  capture_reg,   capture_next;

    res_t               out_data_reg,  out_data_next;
    logic               out_valid_reg, out_valid_next;
    res_t               skid_data_reg, skid_data_next;
    logic               skid_valid_reg, skid_valid_next;

    res_t               beat;
    logic               has_beat;
    logic               in_fire;
    logic               out_fire;
    logic               push;
    logic [COUNT_W-1:0] count_dec;
    logic [WORD_W-1:0]  capture_shift;
    logic               busy;

    assign cmd.ready = !skid_valid_reg;
    assign in_fire   = cmd.valid && cmd.ready;
    assign out_fire  = out_valid_reg && res.ready;
    assign push      = in_fire && has_beat;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    assign busy          = (cmd_kind_reg != KIND_IDLE);
    assign count_dec     = bits_left_reg - COUNT_W'(1);
    assign capture_shift = {cmd.data.data_pin_in, capture_reg[WORD_W-1:1]};

    always_comb
    begin
        shift_next      = shift_reg;
        bits_left_next  = bits_left_reg;
        cmd_kind_next   = cmd_kind_reg;
        read_phase_next = read_phase_reg;
        capture_next    = capture_reg;
        beat            = '0;
        has_beat        = 1'b0;

        case (cmd.data.kind)
            KIND_TICK:
            begin
                has_beat = 1'b1;
                if (!busy)
                begin
                    beat.data_pin_drive = 1'b1;
                end
                else if (read_phase_reg)
                begin
                    capture_next       = capture_shift;
                    bits_left_next     = count_dec;
                    beat.clock_active  = 1'b1;
                    if (count_dec == '0)
                    begin
                        beat.read_word  = capture_shift;
                        beat.word_valid = 1'b1;
                        beat.last_bit   = 1'b1;
                        cmd_kind_next   = KIND_IDLE;
                        read_phase_next = 1'b0;
                    end
                end
                else
                begin
                    beat.clock_active   = 1'b1;
                    beat.data_pin_drive = 1'b1;
                    bits_left_next      = count_dec;
                    if (cmd_kind_reg == KIND_KEY)
                    begin
                        beat.data_pin_out = shift_reg[31];
                        shift_next        = {shift_reg[30:0], 1'b0};
                    end
                    else
                    begin
                        beat.data_pin_out = shift_reg[0];
                        shift_next        = {1'b0, shift_reg[31:1]};
                    end
                    if (count_dec == '0)
                    begin
                        if (cmd_kind_reg == KIND_REGOUT)
                        begin
                            read_phase_next = 1'b1;
                            bits_left_next  = READ_CLOCKS;
                            capture_next    = '0;
                        end
                        else
                        begin
                            beat.last_bit = 1'b1;
                            cmd_kind_next = KIND_IDLE;
                        end
                    end
                end
            end
            KIND_SIX, KIND_REGOUT, KIND_KEY, KIND_BIT:
            begin
                if (busy)
                begin
                    has_beat             = 1'b1;
                    beat.command_dropped = 1'b1;
                end
                else
                begin
                    read_phase_next = 1'b0;
                    capture_next    = '0;
                    cmd_kind_next   = cmd.data.kind;
                    case (cmd.data.kind)
                        KIND_SIX:
                        begin
                            shift_next     = {4'b0, cmd.data.payload[23:0], 4'b0};
                            bits_left_next = SIX_CLOCKS;
                        end
                        KIND_REGOUT:
                        begin
                            shift_next     = REGOUT_CTRL;
                            bits_left_next = REGOUT_CLOCKS;
                        end
                        KIND_KEY:
                        begin
                            shift_next     = cmd.data.payload;
                            bits_left_next = KEY_CLOCKS;
                        end
                        default:
                        begin
                            shift_next     = {31'b0, cmd.data.payload[0]};
                            bits_left_next = BIT_CLOCKS;
                        end
                    endcase
                end
            end
            default:
            begin
                has_beat = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = beat;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = beat;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            bits_left_reg  <= '0;
            cmd_kind_reg   <= KIND_IDLE;
            read_phase_reg <= 1'b0;
            capture_reg    <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                shift_reg      <= shift_next;
                bits_left_reg  <= bits_left_next;
                cmd_kind_reg   <= cmd_kind_next;
                read_phase_reg <= read_phase_next;
                capture_reg    <= capture_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `ASSERT_SAME(a_idle_no_count, cmd_kind_reg == KIND_IDLE,
                 bits_left_reg == '0 && !read_phase_reg)
    `ASSERT_SAME(a_read_only_regout, read_phase_reg, cmd_kind_reg == KIND_REGOUT)
    `ASSERT_SAME(a_word_on_last, res.valid && res.data.word_valid,
                 res.data.last_bit && !res.data.data_pin_drive)
    `ASSERT_NEXT(a_skid_stalls_in, skid_valid_reg && !res.ready, !cmd.ready)

endmodule
